FILE: design/assert_macros.svh
// Assertion macros used by the decoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled in reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Condition that must never hold.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    `ASSERT_CLK(label, clk, rst_n, !(expr))

`endif

FILE: design/ldr_pkg.sv
// Types and constants of the line delta RLE decoder.
`timescale 1ns / 1ps
`default_nettype none
package ldr_pkg;

    localparam logic [4:0] SUBST_RUN = 5'd22;

    typedef enum logic [1:0] {
        PH_LOW,
        PH_HIGH,
        PH_HIGH_LIT,
        PH_LIT
    } t_phase;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DEC,
        F_END
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_RD,
        B_EMIT
    } t_back_state;

    typedef enum logic [2:0] {
        CMD_LIT,
        CMD_PREV,
        CMD_PREV2,
        CMD_LINE,
        CMD_LINE1
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] value;
        logic [4:0] count;
        logic       last;
        logic       done;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_push;

endpackage
`default_nettype wire

FILE: design/ldr_in_if.sv
// Input channel: compressed stream bytes.
`timescale 1ns / 1ps
`default_nettype none
interface ldr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] comp_byte;
    modport source(output valid, output comp_byte, input ready);
    modport sink(input valid, input comp_byte, output ready);
endinterface
`default_nettype wire

FILE: design/ldr_out_if.sv
// Output channel: decompressed bytes with run and frame flags.
`timescale 1ns / 1ps
`default_nettype none
interface ldr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_done;
    modport source(output valid, output out_byte, output run_last, output frame_done,
                   input ready);
    modport sink(input valid, input out_byte, input run_last, input frame_done,
                 output ready);
endinterface
`default_nettype wire

FILE: design/ldr_front.sv
// Front end: takes stream bytes, decodes control bits into run and literal commands.
`timescale 1ns / 1ps
`default_nettype none
module ldr_front #(
    parameter int SIZE_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ldr_in_if.sink               i_in,
    input  logic [SIZE_BITS-1:0] i_out_size,
    input  logic                 i_q_full,
    output ldr_pkg::t_q_push     o_q_push
);
    import ldr_pkg::*;

    t_front_state         r_state, n_state;
    t_phase               r_phase, n_phase;
    logic [15:0]          r_word, n_word;
    logic [4:0]           r_bits, n_bits;
    logic [5:0]           r_pcode, n_pcode;
    logic [2:0]           r_plen, n_plen;
    logic                 r_high, n_high;
    logic [SIZE_BITS-1:0] r_count, n_count;
    logic                 r_pend_v, n_pend_v;
    t_cmd                 r_pend, n_pend;

    logic                 accept;
    logic                 complete;
    logic [SIZE_BITS-1:0] rem;
    logic                 blocked;
    logic                 dec_more;
    logic                 d_bit;
    logic [5:0]           d_code;
    logic [2:0]           d_len;
    logic                 d_lit;
    logic                 d_run;
    logic [2:0]           d_nf;
    logic [4:0]           run_n;
    logic                 run_done;
    t_cmd                 run_cmd;
    t_cmd                 last_cmd;

    assign accept   = i_in.valid && i_in.ready;
    assign complete = r_count >= i_out_size;
    assign rem      = i_out_size - r_count;
    assign blocked  = r_pend_v && i_q_full;
    assign dec_more = (r_bits != 5'd0) && !complete;
    assign i_in.ready = (r_state == F_IDLE);

    assign d_bit  = r_word[0];
    assign d_code = r_pcode | (6'(d_bit) << r_plen);
    assign d_len  = r_plen + 3'd1;
    assign d_lit  = (d_len == 3'd1) && !d_bit;
    assign d_run  = ((d_len == 3'd3) && !d_code[2]) || (d_len >= 3'd6);
    assign d_nf   = d_code[5:3];

    always_comb begin
        run_cmd       = '0;
        run_cmd.value = 8'd0;
        if (d_len == 3'd3) begin
            run_cmd.kind = d_code[1] ? CMD_LINE : CMD_PREV;
            run_n        = 5'd1;
        end else if (d_nf == 3'd1) begin
            run_cmd.kind = d_code[1] ? CMD_LINE1 : CMD_PREV2;
            run_n        = 5'd1;
        end else begin
            run_cmd.kind = d_code[1] ? CMD_LINE : CMD_PREV;
            run_n        = (d_nf == 3'd0) ? SUBST_RUN : 5'(d_nf);
        end
        run_done      = SIZE_BITS'(run_n) >= rem;
        run_cmd.count = run_done ? 5'(rem) : run_n;
        run_cmd.done  = run_done;
        run_cmd.last  = 1'b0;
    end

    always_comb begin
        last_cmd      = r_pend;
        last_cmd.last = 1'b1;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (accept && !complete && r_phase != PH_HIGH_LIT) n_state = F_DEC;
            end
            F_DEC: begin
                if (!dec_more) n_state = F_END;
                else if (!blocked && d_lit) n_state = F_END;
            end
            F_END: begin
                if (!r_pend_v || !i_q_full) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        n_phase  = r_phase;
        n_word   = r_word;
        n_bits   = r_bits;
        n_pcode  = r_pcode;
        n_plen   = r_plen;
        n_high   = r_high;
        n_count  = r_count;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        o_q_push = '0;
        case (r_state)
            F_IDLE: begin
                if (accept && !complete) begin
                    case (r_phase)
                        PH_LOW: begin
                            n_word = 16'(i_in.comp_byte);
                            n_bits = 5'd8;
                            n_high = 1'b0;
                        end
                        PH_HIGH, PH_HIGH_LIT: begin
                            n_word = r_word | (16'(i_in.comp_byte) << r_bits[2:0]);
                            n_bits = {2'b01, r_bits[2:0]};
                            n_high = 1'b1;
                            if (r_phase == PH_HIGH_LIT) n_phase = PH_LIT;
                        end
                        PH_LIT: begin
                            n_pend_v     = 1'b1;
                            n_pend.kind  = CMD_LIT;
                            n_pend.value = i_in.comp_byte;
                            n_pend.count = 5'd1;
                            n_pend.last  = 1'b0;
                            n_pend.done  = (rem == SIZE_BITS'(1));
                            n_count      = r_count + SIZE_BITS'(1);
                            n_high       = 1'b1;
                        end
                        default: n_phase = PH_LOW;
                    endcase
                end
            end
            F_DEC: begin
                if (dec_more) begin
                    if (!blocked) begin
                        n_word = r_word >> 1;
                        n_bits = r_bits - 5'd1;
                        if (d_lit) begin
                            n_pcode = 6'd0;
                            n_plen  = 3'd0;
                            n_phase = r_high ? PH_LIT : PH_HIGH_LIT;
                        end else if (d_run) begin
                            n_pcode        = 6'd0;
                            n_plen         = 3'd0;
                            o_q_push.valid = r_pend_v;
                            o_q_push.cmd   = r_pend;
                            n_pend_v       = 1'b1;
                            n_pend         = run_cmd;
                            n_count        = r_count + SIZE_BITS'(run_cmd.count);
                        end else begin
                            n_pcode = d_code;
                            n_plen  = d_len;
                        end
                    end
                end else if (complete) begin
                    n_word  = 16'd0;
                    n_bits  = 5'd0;
                    n_pcode = 6'd0;
                    n_plen  = 3'd0;
                    n_phase = PH_LOW;
                end else begin
                    n_phase = r_high ? PH_LOW : PH_HIGH;
                end
            end
            F_END: begin
                if (r_pend_v && !i_q_full) begin
                    o_q_push.valid = 1'b1;
                    o_q_push.cmd   = last_cmd;
                    n_pend_v       = 1'b0;
                end
            end
            default: n_pend_v = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_IDLE;
            r_phase  <= PH_LOW;
            r_word   <= '0;
            r_bits   <= '0;
            r_pcode  <= '0;
            r_plen   <= '0;
            r_high   <= 1'b0;
            r_count  <= '0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_word   <= n_word;
            r_bits   <= n_bits;
            r_pcode  <= n_pcode;
            r_plen   <= n_plen;
            r_high   <= n_high;
            r_count  <= n_count;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

endmodule
`default_nettype wire

FILE: design/ldr_cmd_fifo.sv
// Two-entry command queue between front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module ldr_cmd_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ldr_pkg::t_q_push i_push,
    output logic             o_full,
    output logic             o_empty,
    output ldr_pkg::t_cmd    o_cmd,
    input  logic             i_pop
);
    import ldr_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_push.cmd;
    end

endmodule
`default_nettype wire

FILE: design/ldr_back.sv
// Back end: runs commands byte by byte over the line buffer.
`timescale 1ns / 1ps
`default_nettype none
module ldr_back #(
    parameter int MAX_LINE  = 4096,
    parameter int SIZE_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [12:0]          i_line_width,
    input  logic [SIZE_BITS-1:0] i_out_size,
    input  logic                 i_q_empty,
    input  ldr_pkg::t_cmd        i_q_cmd,
    output logic                 o_q_pop,
    ldr_out_if.source            o_out
);
    import ldr_pkg::*;

    localparam int PW  = $clog2(MAX_LINE);
    localparam int EW  = $clog2(MAX_LINE + 1);
    localparam int CW0 = (SIZE_BITS > 13) ? SIZE_BITS : 13;
    localparam int CW  = (CW0 > EW) ? CW0 : EW;

    t_back_state   r_state, n_state;
    t_cmd          r_cmd;
    logic [4:0]    r_left;
    logic [PW-1:0] r_ptr;
    logic [7:0]    r_prev;
    logic [7:0]    r_prev2;
    logic [7:0]    r_rd;
    logic          r_ovalid;
    logic [7:0]    r_obyte;
    logic          r_olast;
    logic          r_odone;

    logic [7:0]    mem [MAX_LINE];

    logic [CW-1:0] lw_x;
    logic [CW-1:0] os_x;
    logic [CW-1:0] w_sel;
    logic [CW-1:0] w_clamp;
    logic [EW-1:0] w_e;
    logic [EW-1:0] rd_dist;
    logic [EW:0]   addr_sum;
    logic [PW-1:0] rd_addr;
    logic [PW-1:0] ptr_next;
    logic          emit_ok;
    logic [7:0]    byte_val;

    assign lw_x  = CW'(i_line_width);
    assign os_x  = CW'(i_out_size);
    assign w_sel = ((lw_x > os_x) || (lw_x <= CW'(1))) ? os_x : lw_x;
    assign w_clamp = (w_sel < CW'(2)) ? CW'(2) :
                     (w_sel > CW'(MAX_LINE)) ? CW'(MAX_LINE) : w_sel;
    assign w_e  = EW'(w_clamp);
    assign rd_dist = (r_cmd.kind == CMD_LINE1) ? (w_e - EW'(1)) : w_e;

    assign addr_sum = (EW + 1)'(r_ptr) - (EW + 1)'(rd_dist)
                    + (((EW + 1)'(r_ptr) >= (EW + 1)'(rd_dist)) ? '0 : (EW + 1)'(MAX_LINE));
    assign rd_addr  = PW'(addr_sum);
    assign ptr_next = (r_ptr == PW'(MAX_LINE - 1)) ? '0 : r_ptr + PW'(1);

    assign emit_ok = (r_state == B_EMIT) && (!r_ovalid || o_out.ready);
    assign o_q_pop = (r_state == B_IDLE) && !i_q_empty;

    assign o_out.valid      = r_ovalid;
    assign o_out.out_byte   = r_obyte;
    assign o_out.run_last   = r_olast;
    assign o_out.frame_done = r_odone;

    always_comb begin
        case (r_cmd.kind)
            CMD_LIT:   byte_val = r_cmd.value;
            CMD_PREV:  byte_val = r_prev;
            CMD_PREV2: byte_val = r_prev2;
            default:   byte_val = r_rd;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: if (!i_q_empty) n_state = B_RD;
            B_RD:   n_state = B_EMIT;
            B_EMIT: begin
                if (emit_ok) n_state = (r_left == 5'd1) ? B_IDLE : B_RD;
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ptr    <= '0;
            r_prev   <= '0;
            r_prev2  <= '0;
            r_ovalid <= 1'b0;
            r_left   <= '0;
        end else begin
            r_state <= n_state;
            if (o_q_pop) r_left <= i_q_cmd.count;
            if (emit_ok) begin
                r_ovalid <= 1'b1;
                r_ptr    <= ptr_next;
                r_prev2  <= r_prev;
                r_prev   <= byte_val;
                r_left   <= r_left - 5'd1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_cmd <= i_q_cmd;
        if (emit_ok) begin
            r_obyte <= byte_val;
            r_olast <= r_cmd.last && (r_left == 5'd1);
            r_odone <= r_cmd.done && (r_left == 5'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_ok) mem[r_ptr] <= byte_val;
        r_rd <= mem[rd_addr];
    end

endmodule
`default_nettype wire

FILE: design/line_delta_rle_decoder_unit.sv
// Top level of the line delta RLE decoder.
//
//  channel  dir  handshake      payload
//  i_in     in   valid/ready    comp_byte[7:0]
//  o_out    out  valid/ready    out_byte[7:0], run_last, frame_done
//  i_cfg_*  in   write enable   idx 0 line_width, idx 1 out_size
//
// After a control byte or a literal byte, the front decodes pending control bits one at a
// time until they run out or a literal flag stops it; a high byte ahead of its literal, or
// a byte after frame completion, is taken without decoding.
// The back end pops a command, then reads and emits each of its bytes before popping the next.
// Synchronous active-low reset; line buffer contents are not cleared.
// A 2-entry queue sits between the ends; output stalls hold the back, a full queue the front.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module line_delta_rle_decoder_unit #(
    parameter int MAX_LINE  = 4096,
    parameter int SIZE_BITS = 24
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ldr_in_if.sink    i_in,
    ldr_out_if.source o_out,
    input  logic i_cfg_we,
    input  logic i_cfg_idx,
    input  logic [((SIZE_BITS > 13) ? SIZE_BITS : 13)-1:0] i_cfg_data
);
    import ldr_pkg::*;

    localparam logic CFG_LINE_WIDTH = 1'b0;
    localparam logic CFG_OUT_SIZE   = 1'b1;

    logic [12:0]          r_line_width;
    logic [SIZE_BITS-1:0] r_out_size;

    t_q_push q_push;
    logic    q_full;
    logic    q_empty;
    t_cmd    q_cmd;
    logic    q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= 13'd2;
            r_out_size   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LINE_WIDTH: r_line_width <= i_cfg_data[12:0];
                CFG_OUT_SIZE:   r_out_size   <= i_cfg_data[SIZE_BITS-1:0];
                default:        r_out_size   <= r_out_size;
            endcase
        end
    end

    ldr_front #(.SIZE_BITS(SIZE_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_out_size (r_out_size),
        .i_q_full   (q_full),
        .o_q_push   (q_push)
    );

    ldr_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    ldr_back #(.MAX_LINE(MAX_LINE), .SIZE_BITS(SIZE_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_line_width (r_line_width),
        .i_out_size   (r_out_size),
        .i_q_empty    (q_empty),
        .i_q_cmd      (q_cmd),
        .o_q_pop      (q_pop),
        .o_out        (o_out)
    );

    `ASSERT_NEVER(a_done_is_last, i_clk, i_rst_n, o_out.valid && o_out.frame_done && !o_out.run_last)
    `ASSERT_NEVER(a_no_q_overflow, i_clk, i_rst_n, q_push.valid && q_full)

endmodule
`default_nettype wire
